// ----- rtl/psov_pkg.sv -----
// Package for the prefix scan with overflow block.
// Holds the input and result word types and the status codes.
// No dependencies.
package psov_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned IndexWidth = 32;
	localparam int unsigned TotalWidth = 33;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	localparam logic MODE_EXCLUSIVE = 1'b0;
	localparam logic MODE_INCLUSIVE = 1'b1;

	typedef struct packed {
		logic [ValueWidth-1:0] value;
		logic                  last;
	} item_word_t;

	typedef struct packed {
		logic [ValueWidth-1:0] prefix;
		logic [IndexWidth-1:0] position;
		logic                  status;
		logic [TotalWidth-1:0] total;
		logic                  end_of_run;
	} result_word_t;

endpackage

// ----- rtl/prefix_scan_with_overflow.sv -----
// Top level of the streaming prefix scan with overflow detection.
// Holds the input register, sequence state, result register and checks.
// Depends on psov_pkg and psov_step.
//
// Usage:
//   Words enter on item/item_valid/item_stall; a word is taken at an edge where
//   item_valid is high and item_stall is low. Results leave on
//   result/result_valid/result_stall under the same rule. Each word gives zero or
//   one result: words after an overflow in a sequence are dropped up to and
//   including the one marked last, which clears the running sum and index.
//   cfg_we/cfg_data write scan_mode (0 exclusive, 1 inclusive); write it only
//   while no word is in flight.
//   A taken word passes the input register and then the result register.
//   Throughput: one word per cycle while the receiver does not stall, set by
//   the single add and carry check between the input and result registers.
//   When the receiver stalls, the result register holds and the input register
//   still takes one more word; item_stall rises only when both are full.
//   Reset clears the sequence state, the mode and both valid flags.
module prefix_scan_with_overflow #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_data,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  psov_pkg::item_word_t   item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output psov_pkg::result_word_t result
);

	psov_pkg::item_word_t   item_s1;
	logic                   item_valid_s1;
	psov_pkg::result_word_t result_q;
	logic                   result_valid_q;
	logic                   mode_q;

	logic [VALUE_BITS-1:0]             sum_q;
	logic [psov_pkg::IndexWidth-1:0]   index_q;
	logic                              ovf_q;

	logic                              emit;
	psov_pkg::result_word_t            step_result;
	logic [VALUE_BITS-1:0]             sum_d;
	logic [psov_pkg::IndexWidth-1:0]   index_d;
	logic                              ovf_d;

	logic advance;
	logic fire;

	assign advance      = !result_valid_q || !result_stall;
	assign fire         = item_valid_s1 && advance;
	assign item_stall   = item_valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	psov_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.word     (item_s1),
		.scan_mode(mode_q),
		.sum_q    (sum_q),
		.index_q  (index_q),
		.ovf_q    (ovf_q),
		.emit     (emit),
		.result   (step_result),
		.sum_d    (sum_d),
		.index_d  (index_d),
		.ovf_d    (ovf_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= psov_pkg::MODE_EXCLUSIVE;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			index_q <= '0;
			ovf_q   <= 1'b0;
		end else if (fire) begin
			sum_q   <= sum_d;
			index_q <= index_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= step_result;
		end
	end

	// An overflow result always closes the run and carries a zero prefix.
	a_overflow_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == psov_pkg::STATUS_OVERFLOW
		|-> result.end_of_run && result.prefix == '0)
		else $error("overflow result without end of run or with nonzero prefix");

	// A successful result never has a total past the value range.
	a_ok_total_fits: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == psov_pkg::STATUS_OK
		|-> result.total[VALUE_BITS] == 1'b0)
		else $error("successful result with a carried total");

	// Words dropped after an overflow never produce a result.
	a_dropped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ovf_q |=> !result_valid)
		else $error("result produced for a dropped word");

	// The input side only stalls when the input register holds a word.
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> item_valid_s1 && result_valid_q)
		else $error("input stalled with room available");

endmodule

// ----- rtl/psov_step.sv -----
// Combinational scan step: one add and carry check against the running sum.
// Produces the result word and the next sequence state for one item.
// Depends on psov_pkg.
module psov_step #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  psov_pkg::item_word_t          word,
	input  logic                          scan_mode,
	input  logic [VALUE_BITS-1:0]         sum_q,
	input  logic [psov_pkg::IndexWidth-1:0] index_q,
	input  logic                          ovf_q,
	output logic                          emit,
	output psov_pkg::result_word_t        result,
	output logic [VALUE_BITS-1:0]         sum_d,
	output logic [psov_pkg::IndexWidth-1:0] index_d,
	output logic                          ovf_d
);

	logic [VALUE_BITS-1:0] operand;
	logic [VALUE_BITS:0]   sum;
	logic                  carry;

	assign operand = word.value[VALUE_BITS-1:0];
	assign sum     = {1'b0, sum_q} + {1'b0, operand};
	assign carry   = sum[VALUE_BITS];

	always_comb begin
		emit              = !ovf_q;
		result.position   = index_q;
		result.total      = psov_pkg::TotalWidth'(sum);
		if (carry) begin
			result.prefix     = '0;
			result.status     = psov_pkg::STATUS_OVERFLOW;
			result.end_of_run = 1'b1;
		end else begin
			result.status     = psov_pkg::STATUS_OK;
			result.end_of_run = word.last;
			if (scan_mode == psov_pkg::MODE_INCLUSIVE) begin
				result.prefix = psov_pkg::ValueWidth'(sum[VALUE_BITS-1:0]);
			end else begin
				result.prefix = psov_pkg::ValueWidth'(sum_q);
			end
		end
	end

	// The last word of a sequence always clears the state, whatever else happened.
	always_comb begin
		sum_d   = sum_q;
		index_d = index_q;
		ovf_d   = ovf_q;
		if (word.last) begin
			sum_d   = '0;
			index_d = '0;
			ovf_d   = 1'b0;
		end else if (!ovf_q) begin
			if (carry) begin
				ovf_d = 1'b1;
			end else begin
				sum_d   = sum[VALUE_BITS-1:0];
				index_d = index_q + 1'b1;
			end
		end
	end

endmodule
